// ===== sv/bba_pkg.sv =====
// bba_pkg: shared types and constants for the bitmap block allocator
// holds the sequencer state type, op and status codes and parameter defaults
// no dependencies
package bba_pkg;

  localparam int BLOCKS_DEFAULT = 16;
  localparam int COUNT_W        = 7;
  localparam int START_W        = 6;
  localparam int SNAP_W         = 16;

  localparam logic FREE = 1'b0;

  localparam logic OP_ALLOC    = 1'b0;
  localparam logic OP_FREE_ALL = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_ROOM = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// ===== sv/bitmap_block_allocator.sv =====
// bitmap_block_allocator: first fit allocator of contiguous runs over a busy bitmap
// one block per cycle scan under a small sequencer, registered result word
// depends on bba_pkg
//
// input channel (in_valid, in_stall): op and block_count. op allocate asks for
// block_count contiguous free blocks, op free all clears the map.
// output channel (out_valid, out_stall): status, start_block and map_snapshot,
// one result word per input word, in order. map_snapshot shows blocks 0 to 15.
// in_stall is high from the accepting edge until the result is loaded into the
// output register, so one word is worked on at a time.
// an allocate scans the map from block 0, one block per cycle, and stops at the
// last block of the first fitting run or, failing that, at block BLOCKS - 1.
// free all, a zero count and a count above BLOCKS skip the scan. the sequencer
// returns to idle as the result is loaded, so the next input word can be
// accepted in the cycle that out_valid rises.
// a stalled result holds the output register; a finished result then waits in
// the sequencer and the next input word is taken once it has moved on.
// rst clears the map to all free and empties the output register.
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int BLOCKS = BLOCKS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [COUNT_W-1:0] block_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic [START_W-1:0] start_block,
  output logic [SNAP_W-1:0]  map_snapshot
);

  localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

  state_t              state, state_next;
  logic [BLOCKS-1:0]   busy_map, busy_map_next;
  logic [BLOCKS-1:0]   run_mask, run_mask_next;
  logic [IW-1:0]       idx, idx_next;
  logic [COUNT_W-1:0]  run, run_next;
  logic [COUNT_W-1:0]  cnt, cnt_next;
  logic                res_status, res_status_next;
  logic [START_W-1:0]  res_start, res_start_next;
  logic                load_out;
  logic [SNAP_W-1:0]   snap;
  logic                blk_free;
  logic [COUNT_W-1:0]  start_calc;

  generate
    if (BLOCKS >= SNAP_W) begin : g_snap_wide
      assign snap = busy_map[SNAP_W-1:0];
    end else begin : g_snap_narrow
      assign snap = {{(SNAP_W-BLOCKS){1'b0}}, busy_map};
    end
  endgenerate

  assign in_stall   = (state != ST_IDLE);
  assign blk_free   = (busy_map[idx] == FREE);
  assign start_calc = COUNT_W'(idx) + COUNT_W'(1) - cnt;

  always_comb begin
    state_next      = state;
    busy_map_next   = busy_map;
    run_mask_next   = run_mask;
    idx_next        = idx;
    run_next        = run;
    cnt_next        = cnt;
    res_status_next = res_status;
    res_start_next  = res_start;
    load_out        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cnt_next        = block_count;
          idx_next        = '0;
          run_next        = '0;
          run_mask_next   = '0;
          res_start_next  = '0;
          res_status_next = STATUS_OK;
          priority if (op == OP_FREE_ALL) begin
            busy_map_next = '0;
            state_next    = ST_DONE;
          end else if (block_count == '0) begin
            state_next = ST_DONE;
          end else if (block_count > COUNT_W'(BLOCKS)) begin
            res_status_next = STATUS_NO_ROOM;
            state_next      = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (blk_free) begin
          run_next = run + COUNT_W'(1);
          for (int k = 0; k < BLOCKS; k++) begin
            run_mask_next[k] = run_mask[k] | (idx == IW'(k));
          end
        end else begin
          run_next      = '0;
          run_mask_next = '0;
        end
        priority if (blk_free && (run_next == cnt)) begin
          busy_map_next   = busy_map | run_mask_next;
          res_status_next = STATUS_OK;
          res_start_next  = start_calc[START_W-1:0];
          state_next      = ST_DONE;
        end else if (idx == IW'(BLOCKS - 1)) begin
          res_status_next = STATUS_NO_ROOM;
          res_start_next  = '0;
          state_next      = ST_DONE;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      busy_map <= '0;
    end else begin
      state    <= state_next;
      busy_map <= busy_map_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    run        <= run_next;
    run_mask   <= run_mask_next;
    cnt        <= cnt_next;
    res_status <= res_status_next;
    res_start  <= res_start_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status       <= res_status;
      start_block  <= res_start;
      map_snapshot <= snap;
    end
  end

endmodule
